### rtl/core/rastree_pkg.sv
// ----------------------------------------------------------------------------
// rastree_pkg
// Shared widths, sizes and codes for the range assign / range sum block.
// ----------------------------------------------------------------------------
package rastree_pkg;

	localparam int LEAVES   = 1024;
	localparam int IDX_W    = 11;              // range bound width, holds LEAVES
	localparam int ADDR_W   = 10;              // element address width
	localparam int VAL_W    = 32;
	localparam int SUM_W    = 42;
	localparam int OFF_W    = 5;               // element offset inside a block
	localparam int BLK_W    = ADDR_W - OFF_W;  // block number width
	localparam int BLK_SIZE = 1 << OFF_W;
	localparam int NBLK     = 1 << BLK_W;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Widen a value to the sum width
	function automatic logic [SUM_W-1:0] sext_val(input logic [VAL_W-1:0] v);
		sext_val = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

endpackage

### rtl/core/rastree_elem_ram.sv
// ----------------------------------------------------------------------------
// rastree_elem_ram
// Element value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rastree_elem_ram
	import rastree_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [VAL_W-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [VAL_W-1:0]  rdata
);

	logic [VAL_W-1:0] mem [LEAVES];

	// Write and read; the read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/range_assign_range_sum_tree.sv
// ----------------------------------------------------------------------------
// range_assign_range_sum_tree
// Range assign and range sum over 1024 signed elements. Elements are grouped
// in blocks of 32; each block keeps its sum and a pending fill value. Fully
// covered blocks are handled in the block table alone, partly covered blocks
// by a sweep over their elements in the element memory.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                  | tuser
//  s_*     | in  | range_lo, range_hi, fill_value, pad | kind
//  m_*     | out | range_sum, pad                      | -
//
//  Work per item: the accept, a block table step per fully covered block, a
//  sweep per partly covered block (at most two: decide, 32 reads, drain),
//  and the posting of a query result; the one-port sweep of the element
//  memory takes the most time.
//  Reset clears all block sums to zero and marks every block as filled
//  with zero, so the element memory needs no clearing.
//  One item is worked on at a time; a result waits in the output register.
// ----------------------------------------------------------------------------
module range_assign_range_sum_tree
	import rastree_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // range_lo[10:0], range_hi[21:11], fill_value[53:22]
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // range_sum[41:0]
);

	typedef enum logic [1:0] {ST_IDLE, ST_BLK, ST_ELEM, ST_DONE} state_t;

	state_t             state_q;
	logic               kind_q;
	logic [IDX_W-1:0]   lo_q, hi_q;
	logic [VAL_W-1:0]   val_q;
	logic [SUM_W-1:0]   acc_q, bacc_q, out_q;
	logic [BLK_W-1:0]   blk_q, last_q;
	logic [OFF_W:0]     cnt_q;
	logic               rd_vld_s1;
	logic [OFF_W-1:0]   rd_off_s1;
	logic               out_vld_q;

	logic               bpend_q [NBLK];
	logic [VAL_W-1:0]   bval_q  [NBLK];
	logic [SUM_W-1:0]   bsum_q  [NBLK];

	// Input unpacking and clamping
	logic [IDX_W-1:0] in_lo, in_hi, lo_c, hi_c, hi_m1;
	logic [VAL_W-1:0] in_val;
	assign in_lo  = s_tdata[10:0];
	assign in_hi  = s_tdata[21:11];
	assign in_val = s_tdata[53:22];
	assign lo_c   = (in_lo > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : in_lo;
	assign hi_c   = (in_hi > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : in_hi;
	assign hi_m1  = hi_c - IDX_W'(1);

	// Block coverage
	logic [IDX_W:0] base, top;
	logic           full;
	assign base = {2'b00, blk_q, {OFF_W{1'b0}}};
	assign top  = base + (IDX_W+1)'(BLK_SIZE);
	assign full = ({1'b0, lo_q} <= base) && (top <= {1'b0, hi_q});

	// Element memory
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [VAL_W-1:0]  wdata, rdata;

	rastree_elem_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Element update for the data stage of the sweep
	logic [IDX_W-1:0] eidx;
	logic             inr;
	logic [VAL_W-1:0] cur, nval;
	assign eidx  = {1'b0, blk_q, rd_off_s1};
	assign inr   = (eidx >= lo_q) && (eidx < hi_q);
	assign cur   = bpend_q[blk_q] ? bval_q[blk_q] : rdata;
	assign nval  = (kind_q == KIND_ASSIGN && inr) ? val_q : cur;
	assign raddr = {blk_q, cnt_q[OFF_W-1:0]};
	assign waddr = {blk_q, rd_off_s1};
	assign wdata = nval;
	assign we    = (state_q == ST_ELEM) && rd_vld_s1 && (kind_q == KIND_ASSIGN);

	logic             last_elem;
	logic [SUM_W-1:0] bsum_new, fill_sum;
	assign last_elem = rd_vld_s1 && (rd_off_s1 == {OFF_W{1'b1}});
	assign bsum_new  = bacc_q + sext_val(nval);
	assign fill_sum  = sext_val(val_q) << OFF_W;

	// Post a query result when the output register is free or draining
	logic post_sum;
	assign post_sum = (state_q == ST_DONE) && (!out_vld_q || m_tready);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(48-SUM_W){1'b0}}, out_q};

	// Sequencer, block table and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_off_s1 <= '0;
			kind_q    <= KIND_ASSIGN;
			lo_q      <= '0;
			hi_q      <= '0;
			val_q     <= '0;
			acc_q     <= '0;
			bacc_q    <= '0;
			blk_q     <= '0;
			last_q    <= '0;
			cnt_q     <= '0;
			for (int i = 0; i < NBLK; i++) begin
				bpend_q[i] <= 1'b1;
				bval_q[i]  <= '0;
				bsum_q[i]  <= '0;
			end
		end else begin
			if (post_sum) begin
				out_q     <= acc_q;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q <= s_tuser[0];
						lo_q   <= lo_c;
						hi_q   <= hi_c;
						val_q  <= in_val;
						acc_q  <= '0;
						blk_q  <= lo_c[ADDR_W-1:OFF_W];
						last_q <= hi_m1[ADDR_W-1:OFF_W];
						if (lo_c < hi_c) begin
							state_q <= ST_BLK;
						end else if (s_tuser[0] == KIND_QUERY) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_BLK: begin
					if (full) begin
						if (kind_q == KIND_ASSIGN) begin
							bpend_q[blk_q] <= 1'b1;
							bval_q[blk_q]  <= val_q;
							bsum_q[blk_q]  <= fill_sum;
						end else begin
							acc_q <= acc_q + bsum_q[blk_q];
						end
						if (blk_q == last_q) begin
							state_q <= (kind_q == KIND_QUERY) ? ST_DONE : ST_IDLE;
						end else begin
							blk_q <= blk_q + BLK_W'(1);
						end
					end else begin
						cnt_q     <= '0;
						bacc_q    <= '0;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_ELEM;
					end
				end
				ST_ELEM: begin
					// Issue reads in order, process each one when its registered read data returns
					rd_vld_s1 <= !cnt_q[OFF_W];
					rd_off_s1 <= cnt_q[OFF_W-1:0];
					if (!cnt_q[OFF_W]) begin
						cnt_q <= cnt_q + (OFF_W+1)'(1);
					end
					if (rd_vld_s1) begin
						bacc_q <= bsum_new;
						if (kind_q == KIND_QUERY && inr) begin
							acc_q <= acc_q + sext_val(cur);
						end
					end
					if (last_elem) begin
						if (kind_q == KIND_ASSIGN) begin
							bpend_q[blk_q] <= 1'b0;
							bsum_q[blk_q]  <= bsum_new;
						end
						if (blk_q == last_q) begin
							state_q <= (kind_q == KIND_QUERY) ? ST_DONE : ST_IDLE;
						end else begin
							blk_q   <= blk_q + BLK_W'(1);
							state_q <= ST_BLK;
						end
					end
				end
				ST_DONE: begin
					if (post_sum) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sim/range_sum_checker.sv
// ----------------------------------------------------------------------------
// range_sum_checker
// Watches both stream channels of the range assign / range sum block, keeps
// a plain element array as the golden image, and compares every query sum.
// ----------------------------------------------------------------------------
module range_sum_checker
	import rastree_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	output int          fail_count,
	output int          sums_pending,
	output int          sums_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VAL_W-1:0] elem_image [LEAVES];
	logic [SUM_W-1:0]        sum_queue [$];

	// Work out the sum of a clamped half-open range of the image
	function automatic logic [SUM_W-1:0] image_sum(input int lo, input int hi);
		logic signed [SUM_W-1:0] acc;
		acc = '0;
		for (int i = lo; i < hi; i++)
			acc += SUM_W'(elem_image[i]);
		return acc;
	endfunction

	assign sums_pending = sum_queue.size();

	always @(posedge clk or negedge arst_n) begin
		int lo, hi;
		logic [SUM_W-1:0] want, got;
		if (!arst_n) begin
			for (int i = 0; i < LEAVES; i++)
				elem_image[i] = '0;
			sum_queue.delete();
			fail_count <= 0;
			sums_seen <= 0;
		end else begin
			// Apply an accepted input transfer
			if (s_tvalid && s_tready) begin
				lo = s_tdata[10:0];
				hi = s_tdata[21:11];
				if (lo > LEAVES) lo = LEAVES;
				if (hi > LEAVES) hi = LEAVES;
				if (s_tuser[0] == KIND_ASSIGN) begin
					for (int i = lo; i < hi; i++)
						elem_image[i] = s_tdata[53:22];
				end else begin
					sum_queue.push_back(lo < hi ? image_sum(lo, hi) : '0);
				end
			end
			// Compare an accepted output transfer
			if (m_tvalid && m_tready) begin
				got = m_tdata[SUM_W-1:0];
				sums_seen <= sums_seen + 1;
				if (sum_queue.size() == 0) begin
					$display("%0t: unexpected sum, expected none, actual %0d", $time,
						$signed(got));
					fail_count <= fail_count + 1;
				end else begin
					want = sum_queue.pop_front();
					if (want !== got) begin
						$display("%0t: range_sum mismatch, expected %0d, actual %0d",
							$time, $signed(want), $signed(got));
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random range assigns and range queries into the range
// assign / range sum block with random gaps and stalls; a checker beside the
// block predicts every sum and counts mismatches.
// ----------------------------------------------------------------------------
module testbench
	import rastree_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	int          fail_count, sums_pending, sums_seen;
	int          assigns_sent = 0, queries_sent = 0;
	bit          hold_sink = 1'b0;

	range_assign_range_sum_tree dut (.*);

	range_sum_checker chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Send one transfer, idling a random number of cycles first
	task automatic send_op(input logic kind, input int lo, input int hi, input int val);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, val[31:0], hi[10:0], lo[10:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == KIND_QUERY) queries_sent++; else assigns_sent++;
	endtask

	// Stop offering and wait until every sum has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sums_pending != 0) @(posedge clk);
	endtask

	// Draw a range, mostly small, sometimes wide or out of bounds
	task automatic rand_range(output int lo, output int hi);
		int r;
		r = $urandom_range(0, 9);
		lo = $urandom_range(0, LEAVES);
		if (r < 5) hi = lo + $urandom_range(0, 40);
		else if (r < 8) hi = $urandom_range(0, 2047);
		else begin
			lo = $urandom_range(0, 2047);
			hi = $urandom_range(0, 2047);
		end
		if (hi > 2047) hi = 2047;
	endtask

	// Random receiver stalls, with a long counted hold-off when asked
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (500) @(posedge clk);
				hold_sink = 1'b0;
				m_tready <= 1'b1;
			end else begin
				stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
				if (stall == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	initial begin
		int lo, hi;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, empty and clamped ranges
		send_op(KIND_QUERY, 0, LEAVES, 0);
		send_op(KIND_ASSIGN, 0, LEAVES, 32'h7fffffff);
		send_op(KIND_QUERY, 0, LEAVES, 0);
		send_op(KIND_ASSIGN, 0, 2047, 32'h80000000);
		send_op(KIND_QUERY, 0, 2047, 0);
		send_op(KIND_QUERY, 2047, 2047, 0);
		send_op(KIND_ASSIGN, 5, 5, 123);
		send_op(KIND_ASSIGN, 9, 3, 321);
		send_op(KIND_QUERY, 9, 3, 0);
		send_op(KIND_QUERY, 1024, 1024, 0);
		send_op(KIND_ASSIGN, 1023, 1024, 32'hffffffff);
		send_op(KIND_ASSIGN, 0, 1, 32'h55555555);
		send_op(KIND_ASSIGN, 31, 33, 32'haaaaaaaa);
		send_op(KIND_QUERY, 0, 1, 0);
		send_op(KIND_QUERY, 1023, 2047, 0);
		send_op(KIND_QUERY, 30, 34, 0);
		send_op(KIND_ASSIGN, 1365, 682, 7);
		send_op(KIND_ASSIGN, 682, 1365, -7);
		send_op(KIND_QUERY, 1, 1023, 0);
		send_op(KIND_QUERY, 0, LEAVES, 0);

		// Pause until every sum has arrived
		drain();

		// Random mix; a long receiver hold-off in the middle
		for (int n = 0; n < 1430; n++) begin
			if (n == 400) hold_sink = 1'b1;
			if (n == 800) drain();
			rand_range(lo, hi);
			send_op($urandom_range(0, 1), lo, hi, $urandom());
		end

		fork
			drain();
			begin
				repeat (200000) @(posedge clk);
				$display("RESULT: ERROR");
				$finish;
			end
		join_any
		repeat (200) @(posedge clk);
		$display("Sent %0d assigns and %0d queries (empty, clamped, full ranges);",
			assigns_sent, queries_sent);
		$display("checked %0d sums under random gaps, stalls and a long hold-off.",
			sums_seen);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Overall limit
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
